// ----- src/tms_pkg.sv -----
package tms_pkg;

    localparam int NOTE_DEPTH_DEF = 64;

    localparam int NUM_W  = 24;
    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int MS_W   = 20;
    localparam int WAVE_W = 16;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 24;
    localparam int NOTE_W = FREQ_W + DUR_W;

    localparam logic [NUM_W-1:0] NUMER_RST  = 24'd10000000;
    localparam logic [DUR_W-1:0] END_RST    = 16'hFFFF;
    localparam logic [DUR_W-1:0] REPEAT_RST = 16'hFFFE;

    // Reciprocal of three for 16-bit values: x / 3 == (x * 43691) >> 17
    localparam logic [16:0] RECIP3 = 17'd43691;
    localparam int RECIP3_SH = 17;
    localparam logic [MS_W-1:0] GAP_EXTRA = 20'd2;

    typedef enum logic [2:0] {
        FN_LOAD    = 3'd0,
        FN_MELODY  = 3'd1,
        FN_PLAY    = 3'd2,
        FN_CANCEL  = 3'd3,
        FN_COUNT   = 3'd4,
        FN_MS      = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        CFG_NUMER  = 2'd0,
        CFG_END    = 2'd1,
        CFG_REPEAT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TONE = 2'd1,
        PH_GAP  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CHECK,
        S_TSEL,
        S_DIVW,
        S_APPLY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        func;
        logic [IDX_W-1:0]  entry_index;
        logic [FREQ_W-1:0] tone_freq;
        logic [DUR_W-1:0]  tone_duration;
    } t_req;

    typedef struct packed {
        logic             speaker;
        logic             busy_res;
        logic             melody_on;
        logic [IDX_W-1:0] current_entry;
    } t_res;

    typedef struct packed {
        logic cap;
        logic exec;
        logic rd;
        logic stop;
        logic ptr_zero;
        logic take_note;
        logic div_go;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       gap_expire;
        logic       is_end;
        logic       is_rep;
        logic       freq_zero;
        logic       div_done;
    } t_stat;

endpackage

// ----- src/tms_ram.sv -----
module tms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tms_div.sv -----
module tms_div
    import tms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [FREQ_W-1:0] i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_run, n_run;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_q, n_q;
    logic [FREQ_W-1:0] r_rem, n_rem;
    logic [FREQ_W-1:0] r_den, n_den;
    logic [FREQ_W:0]   w_trial;

    // One quotient bit per cycle, restoring form
    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        w_trial = {r_rem, r_q[NUM_W-1]};
        if (i_go) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_q   = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (r_run) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = FREQ_W'(w_trial - {1'b0, r_den});
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[FREQ_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ----- src/tms_ctrl.sv -----
module tms_ctrl
    import tms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy,
    output logic  o_valid
);

    t_state r_state, n_state;
    logic   r_again, n_again;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_again <= 1'b0;
        end else begin
            r_state <= n_state;
            r_again <= n_again;
        end
    end

    always_comb begin
        n_state = r_state;
        n_again = r_again;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_again    = 1'b0;
                if (i_stat.func == FN_MELODY) begin
                    n_state = S_READ;
                end else if (i_stat.func == FN_PLAY) begin
                    n_state = S_TSEL;
                end else if (i_stat.func == FN_MS && i_stat.gap_expire) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                // entry 0 after a repeat plays as it is
                priority if (r_again) begin
                    o_cmd.take_note = 1'b1;
                    n_state         = S_TSEL;
                end else if (i_stat.is_end) begin
                    o_cmd.stop = 1'b1;
                    n_state    = S_DONE;
                end else if (i_stat.is_rep) begin
                    o_cmd.ptr_zero = 1'b1;
                    n_again        = 1'b1;
                    n_state        = S_READ;
                end else begin
                    o_cmd.take_note = 1'b1;
                    n_state         = S_TSEL;
                end
            end
            S_TSEL: begin
                if (i_stat.freq_zero) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ----- src/tms_dp.sv -----
module tms_dp
    import tms_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_stat            o_stat,
    output t_res             o_res
);

    localparam int AW = $clog2(NOTE_DEPTH);

    // Configuration
    logic [NUM_W-1:0] r_numer;
    logic [DUR_W-1:0] r_end, r_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numer <= NUMER_RST;
            r_end   <= END_RST;
            r_rep   <= REPEAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUMER:  r_numer <= i_cfg_data;
                CFG_END:    r_end   <= i_cfg_data[DUR_W-1:0];
                CFG_REPEAT: r_rep   <= i_cfg_data[DUR_W-1:0];
                default:    ;
            endcase
        end
    end

    t_req              r_req;
    logic [AW-1:0]     r_wsel;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic              r_melody, n_melody;
    logic              r_busy, n_busy;
    t_phase            r_phase, n_phase;
    logic [MS_W-1:0]   r_ms, n_ms;
    logic [WAVE_W-1:0] r_wave, n_wave;
    logic [WAVE_W-1:0] r_wrap, n_wrap;
    logic [WAVE_W-1:0] r_high, n_high;
    logic              r_oe, n_oe;
    logic [DUR_W-1:0]  r_last, n_last;
    logic [FREQ_W-1:0] r_tfreq, n_tfreq;
    logic [DUR_W-1:0]  r_tdur, n_tdur;

    logic [NOTE_W-1:0] w_rdata;
    logic [IDX_W-1:0]  w_rem;
    logic [31:0]       w_rem_ext;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quo;
    logic [WAVE_W-1:0] w_per;
    logic [32:0]       w_gap_prod;
    logic [MS_W-1:0]   w_gap_ms;
    logic [MS_W-1:0]   w_tone_ms;
    logic [31:0]       w_ptr_ext;
    logic              w_ms_low;

    // entry_index modulo depth by conditional subtraction
    always_comb begin
        w_rem = i_req.entry_index;
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if (32'(w_rem) >= (NOTE_DEPTH << k)) begin
                w_rem = w_rem - IDX_W'(NOTE_DEPTH << k);
            end
        end
        w_rem_ext = 32'(w_rem);
    end

    tms_ram #(
        .WIDTH(NOTE_W),
        .DEPTH(NOTE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.exec && r_req.func == FN_LOAD),
        .i_waddr(r_wsel),
        .i_wdata({r_req.tone_freq, r_req.tone_duration}),
        .i_re   (i_cmd.rd),
        .i_raddr(r_ptr),
        .o_rdata(w_rdata)
    );

    tms_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.div_go),
        .i_num  (r_numer),
        .i_den  (r_tfreq),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    assign w_per      = (w_quo[NUM_W-1:WAVE_W] != '0) ? '1 : w_quo[WAVE_W-1:0];
    assign w_gap_prod = 33'(r_last) * 33'(RECIP3);
    assign w_gap_ms   = MS_W'(w_gap_prod >> RECIP3_SH) + GAP_EXTRA;
    assign w_tone_ms  = MS_W'({r_tdur, 3'b000}) + MS_W'({r_tdur, 1'b0});
    assign w_ms_low   = (r_ms[MS_W-1:1] == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req  <= i_req;
            r_wsel <= w_rem_ext[AW-1:0];
        end
    end

    always_comb begin
        n_ptr    = r_ptr;
        n_melody = r_melody;
        n_busy   = r_busy;
        n_phase  = r_phase;
        n_ms     = r_ms;
        n_wave   = r_wave;
        n_wrap   = r_wrap;
        n_high   = r_high;
        n_oe     = r_oe;
        n_last   = r_last;
        n_tfreq  = r_tfreq;
        n_tdur   = r_tdur;
        if (i_cmd.exec) begin
            unique case (r_req.func)
                FN_MELODY: begin
                    n_melody = 1'b1;
                    n_busy   = 1'b1;
                    n_ptr    = '0;
                    n_oe     = 1'b0;
                    n_phase  = PH_IDLE;
                    n_ms     = '0;
                end
                FN_PLAY: begin
                    n_tfreq = r_req.tone_freq;
                    n_tdur  = r_req.tone_duration;
                end
                FN_CANCEL: begin
                    n_melody = 1'b0;
                    n_busy   = 1'b0;
                    n_ptr    = '0;
                    n_oe     = 1'b0;
                    n_phase  = PH_IDLE;
                    n_ms     = '0;
                end
                FN_COUNT: begin
                    if (r_oe) begin
                        n_wave = (r_wave >= r_wrap) ? '0 : r_wave + 1'b1;
                    end
                end
                FN_MS: begin
                    if (r_phase != PH_IDLE) begin
                        if (!w_ms_low) begin
                            n_ms = r_ms - 1'b1;
                        end else if (r_phase == PH_TONE) begin
                            n_oe = 1'b0;
                            if (r_melody) begin
                                n_phase = PH_GAP;
                                n_ms    = w_gap_ms;
                            end else begin
                                n_busy  = 1'b0;
                                n_phase = PH_IDLE;
                                n_ms    = '0;
                            end
                        end else begin
                            n_ptr = (32'(r_ptr) == NOTE_DEPTH - 1) ? '0 : r_ptr + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.stop) begin
            n_melody = 1'b0;
            n_busy   = 1'b0;
            n_ptr    = '0;
            n_oe     = 1'b0;
            n_phase  = PH_IDLE;
            n_ms     = '0;
        end
        if (i_cmd.ptr_zero) begin
            n_ptr = '0;
        end
        if (i_cmd.take_note) begin
            n_last  = w_rdata[DUR_W-1:0];
            n_tdur  = w_rdata[DUR_W-1:0];
            n_tfreq = w_rdata[NOTE_W-1:DUR_W];
        end
        if (i_cmd.apply) begin
            if (r_tfreq == '0) begin
                n_oe = 1'b0;
            end else begin
                n_wrap = w_per;
                n_high = w_per >> 1;
                n_wave = '0;
                n_oe   = 1'b1;
            end
            n_ms    = w_tone_ms;
            n_phase = PH_TONE;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_melody <= 1'b0;
            r_busy   <= 1'b0;
            r_phase  <= PH_IDLE;
            r_ms     <= '0;
            r_wave   <= '0;
            r_wrap   <= '0;
            r_high   <= '0;
            r_oe     <= 1'b0;
            r_last   <= '0;
        end else begin
            r_ptr    <= n_ptr;
            r_melody <= n_melody;
            r_busy   <= n_busy;
            r_phase  <= n_phase;
            r_ms     <= n_ms;
            r_wave   <= n_wave;
            r_wrap   <= n_wrap;
            r_high   <= n_high;
            r_oe     <= n_oe;
            r_last   <= n_last;
        end
        r_tfreq <= n_tfreq;
        r_tdur  <= n_tdur;
    end

    assign w_ptr_ext = 32'(r_ptr);

    always_comb begin
        o_stat            = '0;
        o_stat.func       = r_req.func;
        o_stat.gap_expire = (r_phase == PH_GAP) && w_ms_low;
        o_stat.is_end     = (w_rdata[DUR_W-1:0] == r_end);
        o_stat.is_rep     = (w_rdata[DUR_W-1:0] == r_rep);
        o_stat.freq_zero  = (r_tfreq == '0);
        o_stat.div_done   = w_div_done;
    end

    assign o_res.speaker       = r_oe && (r_wave < r_high);
    assign o_res.busy_res      = r_busy;
    assign o_res.melody_on     = r_melody;
    assign o_res.current_entry = w_ptr_ext[IDX_W-1:0];

endmodule

// ----- src/tone_melody_sequencer_core.sv -----
// Square-wave tone and melody player. Issue a request with start while busy is low;
// every request gives exactly one result, shown on o_res for one cycle with o_valid
// high, and the receiver cannot hold it off. Load, cancel, the count tick and an ms
// tick that ends no gap go from the execute step straight to the result strobe. Play
// frequency runs the period divider, unless the frequency is zero (a rest). Start
// melody and an ms tick that ends a gap first fetch a note: a tone runs the divider,
// a rest does not, the end marker stops the melody, and a repeat marker fetches
// entry 0 again. The long paths are set by the period divider, which produces one
// quotient bit per cycle for its 24-bit quotient and then a registered done flag, and
// by the note memory's registered read. Write configuration only while busy is low.
module tone_melody_sequencer_core
    import tms_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_valid,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequence each request: latch, execute, fetch note, divide, apply, strobe
    tms_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .busy   (busy),
        .o_valid(o_valid)
    );

    // Hold tone, timing and melody state; the note memory and divider live here
    tms_dp #(
        .NOTE_DEPTH(NOTE_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cmd     (w_cmd),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_stat    (w_stat),
        .o_res     (o_res)
    );

endmodule
